### src/lphm_pkg.sv
`default_nettype none
package lphm_pkg;
  localparam int unsigned TableDepth   = 64;
  localparam int unsigned SlotBits     = 6;
  localparam int unsigned CapBits      = 7;
  localparam int unsigned KeyBytes     = 8;
  localparam int unsigned KeyBits      = 64;
  localparam int unsigned ValueBits    = 32;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_SEARCH = 3'd2,
    OP_FIRST  = 3'd3,
    OP_NEXT   = 3'd4,
    OP_RSV5   = 3'd5,
    OP_RSV6   = 3'd6,
    OP_RSV7   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2,
    ST_RSV  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY  = 2'd0,
    MARK_LIVE   = 2'd1,
    MARK_ERASED = 2'd2,
    MARK_RSV    = 2'd3
  } mark_e;

  // front end states
  typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_DONE} fstate_e;

  // back end states
  typedef enum logic [2:0] {
    B_IDLE, B_READ, B_CHECK, B_FETCH, B_WAIT, B_OUT, B_CLEAR
  } bstate_e;

  typedef struct packed {
    logic [2:0]           operation;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SlotBits-1:0]  slot_index;
    logic [KeyBits-1:0]   key_out;
    logic [ValueBits-1:0] value_out;
    logic [CapBits-1:0]   entry_total;
  } rsp_t;

  // classified job handed from front to back
  typedef struct packed {
    op_e                  op;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    logic [SlotBits-1:0]  home;
  } job_t;
endpackage
`default_nettype wire

### src/lphm_ram.sv
`default_nettype none
module lphm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/lphm_front.sv
`default_nettype none
module lphm_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lphm_pkg::req_t        req_i,
  input  wire logic                  req_valid_i,
  output logic                       req_ready_o,
  input  wire logic [lphm_pkg::CapBits-1:0] cap_i,
  output lphm_pkg::job_t             job_o,
  output logic                       job_valid_o,
  input  wire logic                  job_ready_i
);
  import lphm_pkg::*;

  fstate_e            state_q, state_d;
  req_t               req_q, req_d;
  logic [KeyBits-1:0] nkey_q, nkey_d;
  logic [63:0]        h_q, h_d;
  logic [3:0]         idx_q, idx_d;
  logic               term_q, term_d;
  logic [SlotBits-1:0] rem_q, rem_d;
  logic [6:0]         bit_q, bit_d;
  logic [7:0]         byte_w, lc_w;
  logic [CapBits:0]   trial_w;

  always_comb begin
    byte_w = req_q.key[8*idx_q[2:0] +: 8];
    lc_w = (byte_w >= 8'h41 && byte_w <= 8'h5a) ? byte_w + 8'd32 : byte_w;
    trial_w = {1'b0, rem_q, h_q[bit_q[5:0]]};
  end

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    nkey_d = nkey_q;
    h_d = h_q;
    idx_d = idx_q;
    term_d = term_q;
    rem_d = rem_q;
    bit_d = bit_q;
    req_ready_o = 1'b0;
    job_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d = req_i;
          nkey_d = '0;
          h_d = '0;
          idx_d = '0;
          term_d = 1'b0;
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        // one key byte a cycle
        if (!term_q && idx_q < 4'(KeyBytes) && byte_w != 8'd0) begin
          h_d = (h_q << 5) + h_q + 64'(lc_w);
          nkey_d[8*idx_q[2:0] +: 8] = byte_w;
        end else begin
          term_d = 1'b1;
        end
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd7) begin
          state_d = F_MOD;
          rem_d = '0;
          bit_d = 7'd63;
        end
      end
      F_MOD: begin
        // restoring remainder, one hash bit a cycle
        if (trial_w >= (CapBits+1)'(cap_i)) begin
          rem_d = SlotBits'(trial_w - (CapBits+1)'(cap_i));
        end else begin
          rem_d = SlotBits'(trial_w);
        end
        bit_d = bit_q - 7'd1;
        if (bit_q == 7'd0) begin
          state_d = F_DONE;
        end
      end
      F_DONE: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign job_o = '{op: op_e'(req_q.operation), key: nkey_q, value: req_q.value, home: rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    nkey_q <= nkey_d;
    h_q <= h_d;
    idx_q <= idx_d;
    term_q <= term_d;
    rem_q <= rem_d;
    bit_q <= bit_d;
  end
endmodule
`default_nettype wire

### src/lphm_queue.sv
`default_nettype none
module lphm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lphm_pkg::job_t in_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output lphm_pkg::job_t      out_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i
);
  import lphm_pkg::*;

  job_t                    ent_q [QueueDepth];
  logic [QueuePtrBits-1:0] wp_q, rp_q;
  logic [QueueCntBits-1:0] cnt_q;
  logic                    push, pop;

  assign in_ready_o = cnt_q != QueueCntBits'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_o = ent_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : wp_q + QueuePtrBits'(1);
      end
      if (pop) begin
        rp_q <= (rp_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : rp_q + QueuePtrBits'(1);
      end
      cnt_q <= cnt_q + QueueCntBits'(push) - QueueCntBits'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= in_i;
  end

  ap_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntBits'(QueueDepth)) else $error("queue overfilled");
endmodule
`default_nettype wire

### src/lphm_back.sv
`default_nettype none
module lphm_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lphm_pkg::job_t               job_i,
  input  wire logic                         job_valid_i,
  output logic                              job_ready_o,
  input  wire logic [lphm_pkg::CapBits-1:0] cap_i,
  output lphm_pkg::rsp_t                    rsp_o,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i
);
  import lphm_pkg::*;

  bstate_e              state_q, state_d;
  job_t                 job_q, job_d;
  logic [SlotBits-1:0]  pos_q, pos_d, fpos_q, fpos_d, cur_q, cur_d;
  logic [CapBits-1:0]   n_q, n_d, cnt_q, cnt_d, live_q, live_d;
  logic                 found_q, found_d, curset_q, curset_d;
  logic [SlotBits-1:0]  clr_q;
  rsp_t                 rsp_q, rsp_d;
  logic                 mark_we;
  mark_e                mark_wd;
  logic [SlotBits-1:0]  mark_wa;
  logic [1:0]           rmark;
  logic                 kv_we;
  logic [SlotBits-1:0]  raddr;
  logic [KeyBits-1:0]   rkey;
  logic [ValueBits-1:0] rval;
  logic [SlotBits-1:0]  nxt_w, lastc_w;
  mark_e                m_w;
  logic                 match_w;

  lphm_ram #(.Width(KeyBits), .Depth(TableDepth)) u_keys (
    .clk_i, .we_i(kv_we), .waddr_i(pos_q), .wdata_i(job_q.key),
    .raddr_i(raddr), .rdata_o(rkey));
  lphm_ram #(.Width(ValueBits), .Depth(TableDepth)) u_vals (
    .clk_i, .we_i(kv_we), .waddr_i(pos_q), .wdata_i(job_q.value),
    .raddr_i(raddr), .rdata_o(rval));
  // slot marks, read alongside the key
  lphm_ram #(.Width($bits(mark_e)), .Depth(TableDepth)) u_marks (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(mark_wd),
    .raddr_i(raddr), .rdata_o(rmark));

  assign lastc_w = SlotBits'(cap_i - CapBits'(1));
  assign nxt_w = (pos_q == lastc_w) ? '0 : pos_q + SlotBits'(1);
  assign m_w = mark_e'(rmark);
  assign match_w = m_w == MARK_LIVE && rkey == job_q.key;
  assign job_ready_o = state_q == B_IDLE;
  assign rsp_valid_o = state_q == B_OUT;
  assign rsp_o = rsp_q;

  always_comb begin
    state_d = state_q;
    job_d = job_q;
    pos_d = pos_q;
    fpos_d = fpos_q;
    cur_d = cur_q;
    n_d = n_q;
    cnt_d = cnt_q;
    live_d = live_q;
    found_d = found_q;
    curset_d = curset_q;
    rsp_d = rsp_q;
    mark_we = 1'b0;
    mark_wd = MARK_LIVE;
    mark_wa = pos_q;
    kv_we = 1'b0;
    raddr = pos_q;
    unique case (state_q)
      B_CLEAR: begin
        // after reset, writes each slot mark empty in turn
        mark_we = 1'b1;
        mark_wa = clr_q;
        mark_wd = MARK_EMPTY;
        if (clr_q == SlotBits'(TableDepth - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (job_valid_i) begin
          job_d = job_i;
          found_d = 1'b0;
          n_d = '0;
          cnt_d = cap_i;
          pos_d = job_i.home;
          if (job_i.op == OP_FIRST ||
              (job_i.op == OP_NEXT && (!curset_q || CapBits'(cur_q) >= cap_i))) begin
            pos_d = '0;
          end else if (job_i.op == OP_NEXT) begin
            pos_d = (cur_q == lastc_w) ? '0 : cur_q + SlotBits'(1);
            cnt_d = cap_i - CapBits'(1);
          end
          state_d = B_READ;
        end
      end
      B_READ: state_d = B_CHECK;
      B_CHECK: begin
        // checks one slot on each pass through B_READ and B_CHECK; key and mark reads land here
        state_d = B_READ;
        raddr = nxt_w;
        if (n_q >= cnt_q) begin
          state_d = B_WAIT;
        end else begin
          unique case (job_q.op)
            OP_INSERT: begin
              if (m_w != MARK_LIVE) begin
                found_d = 1'b1;
                fpos_d = pos_q;
                kv_we = 1'b1;
                mark_we = 1'b1;
                live_d = live_q + CapBits'(1);
                state_d = B_WAIT;
              end
            end
            OP_ERASE: begin
              if (m_w == MARK_EMPTY) begin
                state_d = B_WAIT;
              end else if (match_w) begin
                mark_we = 1'b1;
                mark_wd = MARK_ERASED;
                if (live_q != '0) live_d = live_q - CapBits'(1);
                if (!found_q) begin
                  found_d = 1'b1;
                  fpos_d = pos_q;
                end
              end
            end
            OP_SEARCH: begin
              if (m_w == MARK_EMPTY) begin
                state_d = B_WAIT;
              end else if (match_w) begin
                found_d = 1'b1;
                fpos_d = pos_q;
                state_d = B_WAIT;
              end
            end
            OP_FIRST, OP_NEXT: begin
              if (m_w == MARK_LIVE) begin
                found_d = 1'b1;
                fpos_d = pos_q;
                state_d = B_WAIT;
              end
            end
            default: state_d = B_WAIT;
          endcase
          n_d = n_q + CapBits'(1);
          if (state_d == B_READ) pos_d = nxt_w;
        end
        if (state_d == B_WAIT) raddr = fpos_d;
      end
      B_WAIT: begin
        raddr = fpos_q;
        state_d = B_FETCH;
      end
      B_FETCH: begin
        raddr = fpos_q;
        rsp_d = '0;
        rsp_d.entry_total = live_q;
        if (!found_q) begin
          rsp_d.status = (job_q.op == OP_INSERT) ? ST_FULL : ST_NONE;
        end else begin
          rsp_d.status = ST_OK;
          rsp_d.slot_index = fpos_q;
          rsp_d.key_out = rkey;
          rsp_d.value_out = rval;
          if (job_q.op != OP_INSERT && job_q.op != OP_ERASE) begin
            cur_d = fpos_q;
            curset_d = 1'b1;
          end
        end
        state_d = B_OUT;
      end
      B_OUT: begin
        if (rsp_ready_i) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      live_q <= '0;
      curset_q <= 1'b0;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      live_q <= live_d;
      curset_q <= curset_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + SlotBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    pos_q <= pos_d;
    fpos_q <= fpos_d;
    cur_q <= cur_d;
    n_q <= n_d;
    cnt_q <= cnt_d;
    found_q <= found_d;
    rsp_q <= rsp_d;
  end

  ap_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CapBits'(TableDepth)) else $error("live count out of range");
  ap_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");
  ap_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kv_we |-> state_q == B_CHECK && job_q.op == OP_INSERT)
    else $error("stray slot write");
endmodule
`default_nettype wire

### src/linear_probe_hash_map_unit.sv
`default_nettype none
// open-addressing key/value table with linear probing, 64 slots. a front end
// normalises the key and hashes it one byte a cycle, then reduces the hash
// modulo the capacity one bit a cycle and offers the job from its F_DONE
// state; a two-entry queue passes it to the back end, which picks it up in
// B_IDLE, probes one slot per B_READ/B_CHECK pair (registered key and mark
// reads) and goes through B_WAIT and B_FETCH to present the result in B_OUT.
// an item probes at most as many slots as the capacity; the front may hash
// the next item while the back still probes. after reset the back end clears
// all 64 slot marks before taking its first job. capacity must be written
// only while idle; the block itself does not enforce it.
module linear_probe_hash_map_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lphm_pkg::req_t               in_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  output lphm_pkg::rsp_t                    out_data_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [lphm_pkg::CapBits-1:0] cfg_data_i
);
  import lphm_pkg::*;

  logic [CapBits-1:0] cap_q, cap_w;
  job_t               fjob, bjob;
  logic               fvalid, fready, bvalid, bready;

  // zero acts as one, anything past the table as the full table
  assign cap_w = (cap_q == '0) ? CapBits'(1) :
                 (cap_q > CapBits'(TableDepth)) ? CapBits'(TableDepth) : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapBits'(TableDepth);
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  lphm_front u_front (
    .clk_i, .rst_ni, .req_i(in_data_i), .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o), .cap_i(cap_w), .job_o(fjob),
    .job_valid_o(fvalid), .job_ready_i(fready));

  lphm_queue u_queue (
    .clk_i, .rst_ni, .in_i(fjob), .in_valid_i(fvalid), .in_ready_o(fready),
    .out_o(bjob), .out_valid_o(bvalid), .out_ready_i(bready));

  lphm_back u_back (
    .clk_i, .rst_ni, .job_i(bjob), .job_valid_i(bvalid), .job_ready_o(bready),
    .cap_i(cap_w), .rsp_o(out_data_o), .rsp_valid_o(out_valid_o),
    .rsp_ready_i(out_ready_i));
endmodule
`default_nettype wire

### tb/sv/tb_linear_probe_hash_map_unit.sv
`timescale 1ns / 1ps
module tb_linear_probe_hash_map_unit;
  import lphm_pkg::*;

  logic   clk_i;
  logic   rst_ni;
  req_t   in_data_i;
  logic   in_valid_i;
  logic   in_ready_o;
  rsp_t   out_data_o;
  logic   out_valid_o;
  logic   out_ready_i;
  logic   cfg_we_i;
  logic [CapBits-1:0] cfg_data_i;

  linear_probe_hash_map_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // long enough to cover the tail of an item that probes the whole table
  localparam int unsigned SettleCycles = 400;
  localparam int unsigned StallLimit   = 30000;
  localparam int unsigned HoldCycles   = 3000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // shadow copy of the table
  logic [KeyBits-1:0]   tbl_keys [TableDepth];
  logic [ValueBits-1:0] tbl_vals [TableDepth];
  mark_e                tbl_marks[TableDepth];
  int unsigned          tbl_live;
  int unsigned          walk_pos;
  bit                   walk_valid;
  logic [CapBits-1:0]   cap_reg;

  rsp_t expected_rsps[$];
  int   mismatches;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   hold_req;
  int   quiet_cycles;

  function automatic logic [KeyBits-1:0] strip_key(logic [KeyBits-1:0] k);
    logic [KeyBits-1:0] r;
    r = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (k[8*i +: 8] == 8'd0) break;
      r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic int unsigned home_of(logic [KeyBits-1:0] k, int unsigned cap);
    logic [63:0] h;
    logic [7:0]  b;
    h = '0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b == 8'd0) break;
      if (b >= "A" && b <= "Z") b = b + 8'd32;
      h = h * 64'd33 + {56'd0, b};
    end
    return int'(h % cap);
  endfunction

  // applies one item to the shadow table and returns its response
  function automatic rsp_t apply_op(req_t rq);
    rsp_t               rs;
    logic [KeyBits-1:0] k;
    int unsigned        cap, pos, fpos, cnt;
    bit                 hit;
    cap  = (cap_reg == 0) ? 1 : (cap_reg > TableDepth) ? TableDepth : cap_reg;
    k    = strip_key(rq.key);
    hit  = 1'b0;
    fpos = 0;
    rs   = '0;
    case (op_e'(rq.operation))
      OP_INSERT: begin
        pos = home_of(k, cap);
        for (int n = 0; n < cap; n++) begin
          if (tbl_marks[pos] != MARK_LIVE) begin
            hit = 1'b1;
            break;
          end
          pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
        if (hit) begin
          tbl_keys[pos]  = k;
          tbl_vals[pos]  = rq.value;
          tbl_marks[pos] = MARK_LIVE;
          tbl_live++;
          rs = '{ST_OK, pos[SlotBits-1:0], k, rq.value, tbl_live[CapBits-1:0]};
        end else begin
          rs = '{ST_FULL, '0, '0, '0, tbl_live[CapBits-1:0]};
        end
        return rs;
      end
      OP_ERASE: begin
        pos = home_of(k, cap);
        for (int n = 0; n < cap && tbl_marks[pos] != MARK_EMPTY; n++) begin
          if (tbl_marks[pos] == MARK_LIVE && tbl_keys[pos] == k) begin
            tbl_marks[pos] = MARK_ERASED;
            if (tbl_live > 0) tbl_live--;
            if (!hit) begin
              hit  = 1'b1;
              fpos = pos;
            end
          end
          pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
        if (!hit) return '{ST_NONE, '0, '0, '0, tbl_live[CapBits-1:0]};
        return '{ST_OK, fpos[SlotBits-1:0], tbl_keys[fpos], tbl_vals[fpos],
                 tbl_live[CapBits-1:0]};
      end
      OP_SEARCH: begin
        pos = home_of(k, cap);
        for (int n = 0; n < cap && tbl_marks[pos] != MARK_EMPTY; n++) begin
          if (tbl_marks[pos] == MARK_LIVE && tbl_keys[pos] == k) begin
            hit  = 1'b1;
            fpos = pos;
            break;
          end
          pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
      end
      OP_FIRST, OP_NEXT: begin
        if (op_e'(rq.operation) == OP_FIRST || !walk_valid || walk_pos >= cap) begin
          pos = 0;
          cnt = cap;
        end else begin
          pos = (walk_pos + 1 == cap) ? 0 : walk_pos + 1;
          cnt = cap - 1;
        end
        for (int n = 0; n < cnt; n++) begin
          if (tbl_marks[pos] == MARK_LIVE) begin
            hit  = 1'b1;
            fpos = pos;
            break;
          end
          pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
      end
      default: ;
    endcase
    if (!hit) return '{ST_NONE, '0, '0, '0, tbl_live[CapBits-1:0]};
    walk_pos   = fpos;
    walk_valid = 1'b1;
    return '{ST_OK, fpos[SlotBits-1:0], tbl_keys[fpos], tbl_vals[fpos],
             tbl_live[CapBits-1:0]};
  endfunction

  // offer one item, predict it at acceptance; valid stays high for the next item
  task automatic offer_item(req_t rq, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_op(rq);
    expected_rsps.push_back(typed ? typed_rsp : predicted);
  endtask

  // sender pauses until every response is back and the block has settled
  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapBits-1:0] cap);
    drain_all();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cap_reg = cap;
  endtask

  // key pool so that inserts, searches and erases meet each other
  logic [KeyBits-1:0] key_pool[16];

  function automatic logic [KeyBits-1:0] pool_word();
    logic [KeyBits-1:0] k;
    int unsigned        len;
    k   = '0;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0:       k[8*i +: 8] = 8'($urandom_range("A", "Z"));
        1, 2:    k[8*i +: 8] = 8'($urandom_range("a", "z"));
        default: k[8*i +: 8] = 8'($urandom_range(1, 255));
      endcase
    end
    return k;
  endfunction

  function automatic logic [KeyBits-1:0] pick_key();
    logic [KeyBits-1:0] k;
    int unsigned        cut;
    k = key_pool[$urandom_range(15)];
    case ($urandom_range(9))
      0: begin
        // flip case of letters: same home slot, different key
        for (int i = 0; i < 8; i++)
          if ((k[8*i +: 8] >= "A" && k[8*i +: 8] <= "Z") ||
              (k[8*i +: 8] >= "a" && k[8*i +: 8] <= "z"))
            k[8*i +: 8] = k[8*i +: 8] ^ 8'h20;
      end
      1: begin
        // junk after the terminator must be ignored
        cut = $urandom_range(7);
        k[8*cut +: 8] = 8'd0;
        for (int i = cut + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom);
      end
      2: k = {$urandom, $urandom};
      default: ;
    endcase
    return k;
  endfunction

  function automatic req_t random_item();
    req_t        rq;
    int unsigned r;
    r = $urandom_range(99);
    rq.operation = (r < 36) ? OP_INSERT : (r < 56) ? OP_ERASE : (r < 76) ? OP_SEARCH :
                   (r < 84) ? OP_FIRST  : (r < 96) ? OP_NEXT  : 3'($urandom_range(5, 7));
    rq.key   = pick_key();
    rq.value = $urandom;
    return rq;
  endfunction

  // directed rows; typed responses only where obvious
  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t rs;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(logic [2:0] op, logic [63:0] k, logic [31:0] v,
                         bit typed = 0, rsp_t rs = '0);
    dir_row_t row;
    row.rq    = '{op, k, v};
    row.typed = typed;
    row.rs    = rs;
    dir_rows.push_back(row);
  endtask

  // response checker and ready generator
  initial begin
    rsp_t exp_rsp;
    int   hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_data_o);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_data_o.status !== exp_rsp.status ||
              out_data_o.slot_index !== exp_rsp.slot_index ||
              out_data_o.key_out !== exp_rsp.key_out ||
              out_data_o.value_out !== exp_rsp.value_out ||
              out_data_o.entry_total !== exp_rsp.entry_total) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_rsp, out_data_o);
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[linear_probe_hash_map_unit] ERROR");
        $finish;
      end
    end
  end

  typedef struct {
    logic [CapBits-1:0] cap;
    int                 tx;
    int                 rx;
  } phase_t;

  initial begin
    phase_t phases[$];
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    hold_req     = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    tbl_live     = 0;
    walk_pos     = 0;
    walk_valid   = 1'b0;
    cap_reg      = 7'd64;
    for (int i = 0; i < TableDepth; i++) begin
      tbl_keys[i]  = '0;
      tbl_vals[i]  = '0;
      tbl_marks[i] = MARK_EMPTY;
    end
    for (int i = 0; i < 16; i++) key_pool[i] = pool_word();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset
    add_row(OP_FIRST,  64'h0, 32'h0, 1, '{ST_NONE, '0, '0, '0, 7'd0});
    add_row(OP_NEXT,   64'h0, 32'h0, 1, '{ST_NONE, '0, '0, '0, 7'd0});
    add_row(OP_SEARCH, 64'h61, 32'h0, 1, '{ST_NONE, '0, '0, '0, 7'd0});
    add_row(OP_ERASE,  64'h61, 32'h0, 1, '{ST_NONE, '0, '0, '0, 7'd0});
    // empty key hashes to slot zero
    add_row(OP_INSERT, 64'h0, 32'hFFFF_FFFF, 1, '{ST_OK, '0, '0, 32'hFFFF_FFFF, 7'd1});
    add_row(OP_RSV5,   64'h61, 32'h1, 1, '{ST_NONE, '0, '0, '0, 7'd1});
    add_row(OP_RSV7,   64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 1, '{ST_NONE, '0, '0, '0, 7'd1});
    add_row(OP_RSV6,   64'h0, 32'h0);
    add_row(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    add_row(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    // case-sensitive match on a shared home slot
    add_row(OP_INSERT, 64'h6241, 32'h1234_5678);
    add_row(OP_SEARCH, 64'h6261, 32'h0);
    add_row(OP_SEARCH, 64'h6241, 32'h0);
    add_row(OP_INSERT, 64'h6241, 32'h8765_4321);
    // bytes after the terminator dropped
    add_row(OP_INSERT, 64'hAA55_0000_007A_0061, 32'h5555_AAAA);
    add_row(OP_SEARCH, 64'h61, 32'h0);
    // walk the live slots, wrapping
    add_row(OP_FIRST,  64'h0, 32'h0);
    add_row(OP_NEXT,   64'h0, 32'h0);
    add_row(OP_NEXT,   64'h0, 32'h0);
    add_row(OP_NEXT,   64'h0, 32'h0);
    add_row(OP_NEXT,   64'h0, 32'h0);
    add_row(OP_NEXT,   64'h0, 32'h0);
    // duplicates all go at once
    add_row(OP_ERASE,  64'h6241, 32'h0);
    add_row(OP_ERASE,  64'h6241, 32'h0);
    add_row(OP_SEARCH, 64'h0, 32'h0);
    foreach (dir_rows[i]) offer_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);

    // back-pressure: the receiver holds off while items keep coming
    hold_req = HoldCycles;
    for (int i = 0; i < 30; i++) offer_item(random_item(), 0, '0);
    drain_all();

    phases = '{'{7'd1, 0, 0}, '{7'd7, 83, 0}, '{7'd64, 0, 83}, '{7'd0, 30, 30},
               '{7'd13, 0, 0}, '{7'd127, 83, 0}, '{7'd100, 0, 83}, '{7'd64, 30, 30}};
    foreach (phases[p]) begin
      write_capacity(phases[p].cap);
      tx_idle_pct  = phases[p].tx;
      rx_stall_pct = phases[p].rx;
      for (int i = 0; i < 240; i++) offer_item(random_item(), 0, '0);
    end

    drain_all();
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("[linear_probe_hash_map_unit] OK");
    else
      $display("[linear_probe_hash_map_unit] ERROR");
    $finish;
  end
endmodule

### filelist.f
src/lphm_pkg.sv
src/lphm_ram.sv
src/lphm_front.sv
src/lphm_queue.sv
src/lphm_back.sv
src/linear_probe_hash_map_unit.sv
tb/sv/tb_linear_probe_hash_map_unit.sv
